### hw/rtl/rcpa_pkg.sv
// rcpa_pkg: shared types, field widths and codes of the refcounted page allocator
// used by rcpa_ctrl, rcpa_datapath and refcounted_page_allocator; no dependencies
`timescale 1ns / 1ps

package rcpa_pkg;

  // default sizing, used as the defaults of the top level parameters
  localparam int DEF_MAX_PAGES = 1024;
  localparam int DEF_REF_BITS  = 16;
  localparam int DEF_GEN_BITS  = 32;

  // device page count after reset
  localparam int RST_DEV_PAGES = 1024;

  // handle and result field widths
  localparam int PAGE_ID_W = 10;
  localparam int HGEN_W    = 32;
  localparam int PHYS_W    = 10;
  localparam int FREE_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int KIND_W    = 2;

  // stream payload layout
  localparam int IN_FIELDS_W  = PAGE_ID_W + HGEN_W + 2 * PHYS_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = KIND_W;
  localparam int OUT_FIELDS_W = PAGE_ID_W + HGEN_W + 2 * PHYS_W + FREE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int OUT_TUSER_W  = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_ADD_REF  = 2'd1,
    KIND_RELEASE  = 2'd2,
    KIND_VALIDATE = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE0_PAGES = 1'b0,
    CFG_DEVICE1_PAGES = 1'b1
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch request, read stack tops
    logic page_rd;   // resolve pops, read page table
    logic exec;      // check, write back, load result
  } rcpa_cmd_t;

endpackage

### hw/rtl/rcpa_ctrl.sv
// rcpa_ctrl: request sequencer and result valid for the refcounted page allocator
// depends on rcpa_pkg
`timescale 1ns / 1ps

module rcpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output rcpa_pkg::rcpa_cmd_t cmd
);
  import rcpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.page_rd = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_nxt   = S_POP;
        end
      end
      S_POP: begin
        cmd.page_rd = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  // one request in flight at a time
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("rcpa_ctrl: request accepted while another is in flight");

  // a new result only follows the execute step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("rcpa_ctrl: result appeared outside the execute step");
`endif

endmodule

### hw/rtl/rcpa_datapath.sv
// rcpa_datapath: free id stacks, page table, handle check and result register
// depends on rcpa_pkg; sequenced by rcpa_ctrl through rcpa_cmd_t
`timescale 1ns / 1ps

module rcpa_datapath #(
  parameter int MAX_PAGES = rcpa_pkg::DEF_MAX_PAGES,
  parameter int REF_BITS  = rcpa_pkg::DEF_REF_BITS,
  parameter int GEN_BITS  = rcpa_pkg::DEF_GEN_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rcpa_pkg::rcpa_cmd_t                cmd,
  input  logic [rcpa_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [rcpa_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  logic                               cfg_we,
  input  logic [rcpa_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [rcpa_pkg::CFG_W-1:0]         cfg_wdata,
  output logic [rcpa_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [rcpa_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import rcpa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int RST_PAGES = (MAX_PAGES < RST_DEV_PAGES) ? MAX_PAGES : RST_DEV_PAGES;

  typedef struct packed {
    logic [IDX_W-1:0]    ph1;
    logic [IDX_W-1:0]    ph0;
    logic [GEN_BITS-1:0] gen;
    logic [REF_BITS-1:0] refc;
  } page_t;

  // memories
  logic [IDX_W-1:0] log_mem [MAX_PAGES];
  logic [IDX_W-1:0] d0_mem  [MAX_PAGES];
  logic [IDX_W-1:0] d1_mem  [MAX_PAGES];
  page_t            page_mem [MAX_PAGES];

  // configuration and stack state
  logic [CNT_W-1:0] d0_pages_r, d1_pages_r, n_log_r;
  logic [CNT_W-1:0] cnt_log_r, cnt_d0_r, cnt_d1_r;
  logic [CNT_W-1:0] wm_log_r, wm_d0_r, wm_d1_r;
  logic [CNT_W-1:0] cnt_log_nxt, cnt_d0_nxt, cnt_d1_nxt;
  logic [CNT_W-1:0] wm_log_nxt, wm_d0_nxt, wm_d1_nxt;
  logic [CNT_W-1:0] d0_new, d1_new, cfg_clamped;
  logic             rebuild;

  // request registers
  kind_t               kind_r;
  logic [PAGE_ID_W-1:0] id_r;
  logic [HGEN_W-1:0]   hgen_r;
  logic [PHYS_W-1:0]   p0_r, p1_r;

  // read data and resolved pops
  logic [IDX_W-1:0] log_rd_r, d0_rd_r, d1_rd_r;
  logic [IDX_W-1:0] nid_r, pop0_r, pop1_r;
  logic [IDX_W-1:0] nid, pop0, pop1, page_addr;
  logic [31:0]      addr_full;
  logic             live, live_r;
  page_t            page_rd_r;

  // execute step
  page_t               pg_s, pg_wdata;
  logic                pg_we;
  logic                push_log, push_d0, push_d1;
  logic                handle_ok, ok;
  logic [CNT_W-1:0]    avail_pre, free_nxt;
  logic [REF_BITS-1:0] ref_dec;
  logic [GEN_BITS-1:0] gen_adv;
  logic [PAGE_ID_W-1:0] oid;
  logic [HGEN_W-1:0]   ogen;
  logic [PHYS_W-1:0]   op0, op1;

  // result register
  logic                 out_ok_r;
  logic [PAGE_ID_W-1:0] out_id_r;
  logic [HGEN_W-1:0]    out_gen_r;
  logic [PHYS_W-1:0]    out_p0_r, out_p1_r;
  logic [FREE_W-1:0]    out_free_r;

  // configuration and rebuild
  assign cfg_clamped = (32'(cfg_wdata) > 32'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                         : CNT_W'(cfg_wdata);
  assign rebuild = !rst_n || cfg_we;

  always_comb begin
    d0_new = d0_pages_r;
    d1_new = d1_pages_r;
    if (!rst_n) begin
      d0_new = CNT_W'(RST_PAGES);
      d1_new = CNT_W'(RST_PAGES);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_DEVICE0_PAGES: d0_new = cfg_clamped;
        CFG_DEVICE1_PAGES: d1_new = cfg_clamped;
        default: ;
      endcase
    end
  end

  // pop resolution: an entry below the low-water mark still holds its fill value
  always_comb begin
    nid  = (cnt_log_r == wm_log_r) ? IDX_W'(n_log_r - cnt_log_r) : log_rd_r;
    pop0 = (cnt_d0_r == wm_d0_r) ? IDX_W'(d0_pages_r - cnt_d0_r) : d0_rd_r;
    pop1 = (cnt_d1_r == wm_d1_r) ? IDX_W'(d1_pages_r - cnt_d1_r) : d1_rd_r;
    addr_full = (kind_r == KIND_ALLOC) ? 32'(nid) : 32'(id_r);
    page_addr = IDX_W'(addr_full);
    // logical ids below this bound were handed out since the last rebuild
    live = addr_full < 32'(n_log_r - wm_log_r);
  end

  // execute step
  always_comb begin
    pg_s.refc = live_r ? page_rd_r.refc : '0;
    pg_s.gen  = live_r ? page_rd_r.gen : '0;
    pg_s.ph0  = page_rd_r.ph0;
    pg_s.ph1  = page_rd_r.ph1;

    handle_ok = (32'(id_r) < 32'(n_log_r)) && (32'(pg_s.gen) == 32'(hgen_r)) &&
                (pg_s.refc != '0) && (32'(pg_s.ph0) == 32'(p0_r)) &&
                (32'(pg_s.ph1) == 32'(p1_r));

    avail_pre = cnt_log_r;
    if (cnt_d0_r < avail_pre) avail_pre = cnt_d0_r;
    if (cnt_d1_r < avail_pre) avail_pre = cnt_d1_r;

    ref_dec = pg_s.refc - REF_BITS'(1);
    gen_adv = pg_s.gen + GEN_BITS'(1);
    if (gen_adv == '0) gen_adv = GEN_BITS'(1);

    cnt_log_nxt = cnt_log_r;
    cnt_d0_nxt  = cnt_d0_r;
    cnt_d1_nxt  = cnt_d1_r;
    wm_log_nxt  = wm_log_r;
    wm_d0_nxt   = wm_d0_r;
    wm_d1_nxt   = wm_d1_r;
    push_log    = 1'b0;
    push_d0     = 1'b0;
    push_d1     = 1'b0;
    pg_we       = 1'b0;
    pg_wdata    = pg_s;
    ok          = 1'b0;
    oid         = id_r;
    ogen        = hgen_r;
    op0         = p0_r;
    op1         = p1_r;

    unique case (kind_r)
      KIND_ALLOC: begin
        if (avail_pre != '0) begin
          ok          = 1'b1;
          cnt_log_nxt = cnt_log_r - CNT_W'(1);
          cnt_d0_nxt  = cnt_d0_r - CNT_W'(1);
          cnt_d1_nxt  = cnt_d1_r - CNT_W'(1);
          if (cnt_log_r == wm_log_r) wm_log_nxt = cnt_log_nxt;
          if (cnt_d0_r == wm_d0_r) wm_d0_nxt = cnt_d0_nxt;
          if (cnt_d1_r == wm_d1_r) wm_d1_nxt = cnt_d1_nxt;
          pg_we         = 1'b1;
          pg_wdata.refc = REF_BITS'(1);
          pg_wdata.ph0  = pop0_r;
          pg_wdata.ph1  = pop1_r;
          oid  = PAGE_ID_W'(nid_r);
          ogen = HGEN_W'(pg_s.gen);
          op0  = PHYS_W'(pop0_r);
          op1  = PHYS_W'(pop1_r);
        end
      end
      KIND_ADD_REF: begin
        if (handle_ok) begin
          ok    = 1'b1;
          pg_we = 1'b1;
          if (pg_s.refc != '1) pg_wdata.refc = pg_s.refc + REF_BITS'(1);
        end
      end
      KIND_RELEASE: begin
        if (handle_ok) begin
          ok            = 1'b1;
          pg_we         = 1'b1;
          pg_wdata.refc = ref_dec;
          if (ref_dec == '0) begin
            pg_wdata.gen = gen_adv;
            push_log     = 32'(cnt_log_r) < 32'(MAX_PAGES);
            push_d0      = 32'(cnt_d0_r) < 32'(MAX_PAGES);
            push_d1      = 32'(cnt_d1_r) < 32'(MAX_PAGES);
          end
        end
      end
      KIND_VALIDATE: ok = handle_ok;
      default: ;
    endcase

    if (push_log) cnt_log_nxt = cnt_log_r + CNT_W'(1);
    if (push_d0) cnt_d0_nxt = cnt_d0_r + CNT_W'(1);
    if (push_d1) cnt_d1_nxt = cnt_d1_r + CNT_W'(1);

    free_nxt = cnt_log_nxt;
    if (cnt_d0_nxt < free_nxt) free_nxt = cnt_d0_nxt;
    if (cnt_d1_nxt < free_nxt) free_nxt = cnt_d1_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rebuild) begin
      d0_pages_r <= d0_new;
      d1_pages_r <= d1_new;
      n_log_r    <= (d0_new < d1_new) ? d0_new : d1_new;
      cnt_log_r  <= (d0_new < d1_new) ? d0_new : d1_new;
      wm_log_r   <= (d0_new < d1_new) ? d0_new : d1_new;
      cnt_d0_r   <= d0_new;
      wm_d0_r    <= d0_new;
      cnt_d1_r   <= d1_new;
      wm_d1_r    <= d1_new;
    end else if (cmd.exec) begin
      cnt_log_r <= cnt_log_nxt;
      cnt_d0_r  <= cnt_d0_nxt;
      cnt_d1_r  <= cnt_d1_nxt;
      wm_log_r  <= wm_log_nxt;
      wm_d0_r   <= wm_d0_nxt;
      wm_d1_r   <= wm_d1_nxt;
    end
  end

  // request capture and pop resolution
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= kind_t'(in_tuser[KIND_W-1:0]);
      id_r   <= in_tdata[PAGE_ID_W-1:0];
      hgen_r <= in_tdata[PAGE_ID_W +: HGEN_W];
      p0_r   <= in_tdata[PAGE_ID_W + HGEN_W +: PHYS_W];
      p1_r   <= in_tdata[PAGE_ID_W + HGEN_W + PHYS_W +: PHYS_W];
    end
    if (cmd.page_rd) begin
      nid_r  <= nid;
      pop0_r <= pop0;
      pop1_r <= pop1;
      live_r <= live;
    end
  end

  // free id stacks
  always_ff @(posedge clk) begin
    if (cmd.capture) log_rd_r <= log_mem[IDX_W'(cnt_log_r - CNT_W'(1))];
    if (cmd.exec && push_log) log_mem[IDX_W'(cnt_log_r)] <= IDX_W'(id_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) d0_rd_r <= d0_mem[IDX_W'(cnt_d0_r - CNT_W'(1))];
    if (cmd.exec && push_d0) d0_mem[IDX_W'(cnt_d0_r)] <= pg_s.ph0;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) d1_rd_r <= d1_mem[IDX_W'(cnt_d1_r - CNT_W'(1))];
    if (cmd.exec && push_d1) d1_mem[IDX_W'(cnt_d1_r)] <= pg_s.ph1;
  end

  // page table
  always_ff @(posedge clk) begin
    if (cmd.page_rd) page_rd_r <= page_mem[page_addr];
    if (cmd.exec && pg_we) page_mem[IDX_W'(addr_full)] <= pg_wdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_ok_r   <= ok;
      out_id_r   <= oid;
      out_gen_r  <= ogen;
      out_p0_r   <= op0;
      out_p1_r   <= op1;
      out_free_r <= FREE_W'(free_nxt);
    end
  end

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_free_r, out_p1_r, out_p0_r, out_gen_r, out_id_r};
  assign out_tuser = OUT_TUSER_W'(out_ok_r);

`ifndef ASSERT_OFF
  // low-water marks never pass the stack depths
  a_watermark: assert property (@(posedge clk) disable iff (!rst_n)
    (wm_log_r <= cnt_log_r) && (wm_d0_r <= cnt_d0_r) && (wm_d1_r <= cnt_d1_r))
    else $error("rcpa_datapath: low-water mark above stack depth");

  // no stack grows past its configured size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_log_r <= n_log_r) && (cnt_d0_r <= d0_pages_r) && (cnt_d1_r <= d1_pages_r))
    else $error("rcpa_datapath: free stack deeper than its page count");
`endif

endmodule

### hw/rtl/refcounted_page_allocator.sv
// refcounted_page_allocator: top level of the refcounted page allocator
// depends on rcpa_pkg, rcpa_ctrl and rcpa_datapath
`timescale 1ns / 1ps

// Requests arrive on the in_ stream: in_tuser carries the operation (allocate, add
// reference, release, validate) and in_tdata the handle. Each request yields one
// result on the out_ stream: out_tuser is the ok flag, out_tdata the new or echoed
// handle plus the number of pages still free.
// A request is taken when in_tvalid and in_tready are both high. It then reads the free
// stack tops, reads the page table entry, and checks the handle and writes back, which
// loads the output register; in_tready returns at the edge that loads the result, so a
// new request is taken only once the previous request has passed its write-back step.
// The output register lets the next request be taken while a result waits. When the
// receiver holds out_tready low, the following request stops in its write-back step
// until the register frees up, and no further request is taken meanwhile.
// Reset (rst_n low, synchronous) and every cfg_ write set the device page counts and
// reinitialize the stacks and page table at once; no clearing pass is needed. Write
// configuration only while no request is in flight.

module refcounted_page_allocator #(
  parameter int MAX_PAGES = rcpa_pkg::DEF_MAX_PAGES,
  parameter int REF_BITS  = rcpa_pkg::DEF_REF_BITS,
  parameter int GEN_BITS  = rcpa_pkg::DEF_GEN_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // page_id, page_generation, phys_dev0, phys_dev1
  input  logic [rcpa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [rcpa_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_page_id, out_generation, out_phys_dev0, out_phys_dev1, free_pages
  output logic [rcpa_pkg::OUT_TDATA_W-1:0] out_tdata,
  // ok
  output logic [rcpa_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                             cfg_we,
  input  logic [rcpa_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [rcpa_pkg::CFG_W-1:0]       cfg_wdata
);
  import rcpa_pkg::*;

  rcpa_cmd_t cmd;

  rcpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rcpa_datapath #(
    .MAX_PAGES (MAX_PAGES),
    .REF_BITS  (REF_BITS),
    .GEN_BITS  (GEN_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
